>>> rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Shared constants, opcodes, state encoding and the interface types of the
// shared remainder unit.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int TASK_IDX_W = 4;

    localparam logic [19:0]        US_WRAP        = 20'd1000000;
    localparam logic signed [21:0] INTERVAL_MAX   = 22'sd1000000;
    localparam logic signed [21:0] INTERVAL_MIN   = -22'sd1000000;
    localparam logic [15:0]        TICK_US_RESET  = 16'd1000;
    localparam logic [20:0]        INTERVAL_RESET = 21'd1000;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_ELAPSED   = 6'b000010,
        ST_CHECK     = 6'b000100,
        ST_SCAN      = 6'b001000,
        ST_WAIT_SCAN = 6'b010000,
        ST_WAIT_ADD  = 6'b100000
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] remainder;
    } mod_rsp_t;

endpackage

>>> rtl/ptd_mod_unit.sv
// ----------------------------------------------------------------------------
// Shared remainder unit
// Restoring bit-serial remainder of a 32-bit dividend by a nonzero 16-bit
// divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptd_mod_unit
    import ptd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic        run_reg,  run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic [16:0] rem_reg,  rem_next;
    logic [31:0] dvd_reg,  dvd_next;
    logic [15:0] div_reg,  div_next;
    logic [16:0] shifted;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        shifted   = {rem_reg[15:0], dvd_reg[31]};
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = 5'd0;
            rem_next = 17'd0;
            dvd_next = req.dividend;
            div_next = req.divisor;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
            end
            else
            begin
                rem_next = shifted;
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[15:0];

endmodule

>>> rtl/periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher core
// Tick scheduler for up to sixteen periodic tasks with drift-compensated
// tick interval and a shared serial remainder unit for due checks.
//
// Channel   Ports                                          Direction
// input     start, busy, opcode, now_us, task_index,       in (busy out)
//           task_period
// result    done, tick_fired, due_mask                     out
// config    cfg_we, cfg_wdata                              in
//
// A transfer is taken when start is high and busy is low; busy is low again
// in the cycle that carries the result strobe.
// A tick passes through ST_ELAPSED and ST_CHECK, then scans every slot in
// turn; each valid task waits on the serial remainder unit, and an empty
// slot is skipped in ST_SCAN. An add to a free slot also waits on the
// remainder unit, a sample without a tick ends in ST_CHECK, and any other
// item returns its result in the cycle after it is taken.
// Reset is asynchronous and active low; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_core
    import ptd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [19:0] now_us,
    input  logic [3:0]  task_index,
    input  logic [15:0] task_period,
    output logic        done,
    output logic        tick_fired,
    output logic [15:0] due_mask,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    state_t                 state_reg,      state_next;
    logic [15:0]            tick_us_reg;
    logic [19:0]            last_reg,       last_next;
    logic signed [20:0]     interval_reg,   interval_next;
    logic [31:0]            tick_count_reg, tick_count_next;
    logic [4:0]             task_count_reg, task_count_next;
    logic [TASK_IDX_W-1:0]  slot_reg,       slot_next;
    logic                   done_reg,       done_next;

    logic [19:0]            now_reg,        now_next;
    logic [19:0]            pass_reg,       pass_next;
    logic [TASK_IDX_W-1:0]  idx_reg,        idx_next;
    logic [15:0]            per_reg,        per_next;
    logic [NUM_TASKS-1:0]   acc_mask_reg,   acc_mask_next;
    logic                   tick_fired_reg, tick_fired_next;
    logic [15:0]            due_mask_reg,   due_mask_next;

    logic [NUM_TASKS-1:0]   valid_reg;
    logic [15:0]            period_reg [NUM_TASKS];
    logic [15:0]            phase_reg  [NUM_TASKS];

    logic                   add_commit;
    logic                   valid_clr;
    logic                   in_range;
    logic                   slot_last;
    logic [20:0]            diff;
    logic signed [21:0]     interval_raw;
    logic [NUM_TASKS-1:0]   acc_upd;
    mod_req_t               mod_req;
    mod_rsp_t               mod_rsp;

    ptd_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign in_range  = ({1'b0, task_index} < 5'(NUM_TASKS));
    assign slot_last = (slot_reg == TASK_IDX_W'(NUM_TASKS - 1));
    assign diff      = {1'b0, now_reg} - {1'b0, last_reg};
    assign interval_raw = $signed({interval_reg[20], interval_reg})
                        + $signed({6'd0, tick_us_reg})
                        - $signed({2'd0, pass_reg});

    always_comb
    begin
        state_next      = state_reg;
        last_next       = last_reg;
        interval_next   = interval_reg;
        tick_count_next = tick_count_reg;
        task_count_next = task_count_reg;
        slot_next       = slot_reg;
        done_next       = 1'b0;
        now_next        = now_reg;
        pass_next       = pass_reg;
        idx_next        = idx_reg;
        per_next        = per_reg;
        acc_mask_next   = acc_mask_reg;
        tick_fired_next = tick_fired_reg;
        due_mask_next   = due_mask_reg;
        add_commit      = 1'b0;
        valid_clr       = 1'b0;
        acc_upd         = acc_mask_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = tick_count_reg;
        mod_req.divisor  = period_reg[slot_reg];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next       = 1'b1;
                    tick_fired_next = 1'b0;
                    due_mask_next   = 16'd0;
                    unique case (opcode)
                        OP_SAMPLE:
                        begin
                            done_next  = 1'b0;
                            now_next   = (now_us >= US_WRAP) ? now_us - US_WRAP : now_us;
                            state_next = ST_ELAPSED;
                        end
                        OP_ADD:
                        begin
                            if (in_range && !valid_reg[task_index])
                            begin
                                done_next        = 1'b0;
                                task_count_next  = task_count_reg + 5'd1;
                                idx_next         = task_index;
                                per_next         = (task_period == 16'd0) ? 16'd1 : task_period;
                                mod_req.start    = 1'b1;
                                mod_req.dividend = {27'd0, task_count_next};
                                mod_req.divisor  = per_next;
                                state_next       = ST_WAIT_ADD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (in_range && valid_reg[task_index])
                            begin
                                valid_clr       = 1'b1;
                                task_count_next = task_count_reg - 5'd1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ELAPSED:
            begin
                pass_next  = diff[20] ? 20'(diff + {1'b0, US_WRAP}) : diff[19:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ($signed({2'd0, pass_reg}) < $signed({interval_reg[20], interval_reg}))
                begin
                    done_next       = 1'b1;
                    tick_fired_next = 1'b0;
                    due_mask_next   = 16'd0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    last_next = now_reg;
                    if (interval_raw > INTERVAL_MAX)
                    begin
                        interval_next = 21'(INTERVAL_MAX);
                    end
                    else if (interval_raw < INTERVAL_MIN)
                    begin
                        interval_next = 21'(INTERVAL_MIN);
                    end
                    else
                    begin
                        interval_next = interval_raw[20:0];
                    end
                    tick_count_next = tick_count_reg + 32'd1;
                    acc_mask_next   = '0;
                    slot_next       = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (valid_reg[slot_reg])
                begin
                    mod_req.start = 1'b1;
                    state_next    = ST_WAIT_SCAN;
                end
                else if (slot_last)
                begin
                    done_next       = 1'b1;
                    tick_fired_next = 1'b1;
                    due_mask_next   = 16'(acc_mask_reg);
                    state_next      = ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + TASK_IDX_W'(1);
                end
            end
            ST_WAIT_SCAN:
            begin
                if (mod_rsp.done)
                begin
                    acc_upd[slot_reg] = (mod_rsp.remainder == phase_reg[slot_reg]);
                    acc_mask_next     = acc_upd;
                    if (slot_last)
                    begin
                        done_next       = 1'b1;
                        tick_fired_next = 1'b1;
                        due_mask_next   = 16'(acc_upd);
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + TASK_IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_WAIT_ADD:
            begin
                if (mod_rsp.done)
                begin
                    add_commit      = 1'b1;
                    done_next       = 1'b1;
                    tick_fired_next = 1'b0;
                    due_mask_next   = 16'd0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_us_reg    <= TICK_US_RESET;
            last_reg       <= 20'd0;
            interval_reg   <= INTERVAL_RESET;
            tick_count_reg <= 32'd0;
            task_count_reg <= 5'd0;
            slot_reg       <= '0;
            done_reg       <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            interval_reg   <= interval_next;
            tick_count_reg <= tick_count_next;
            task_count_reg <= task_count_next;
            slot_reg       <= slot_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                tick_us_reg <= cfg_wdata;
            end
            if (add_commit)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            else if (valid_clr)
            begin
                valid_reg[task_index] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        pass_reg       <= pass_next;
        idx_reg        <= idx_next;
        per_reg        <= per_next;
        acc_mask_reg   <= acc_mask_next;
        tick_fired_reg <= tick_fired_next;
        due_mask_reg   <= due_mask_next;
        if (add_commit)
        begin
            period_reg[idx_reg] <= per_reg;
            phase_reg[idx_reg]  <= mod_rsp.remainder;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign tick_fired = tick_fired_reg;
    assign due_mask   = due_mask_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("Result strobe while the sequencer is still running.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !tick_fired) |-> (due_mask == 16'd0))
        else $error("Due mask set on a result without a tick.");

    assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == ST_WAIT_SCAN || state_reg == ST_WAIT_ADD))
        else $error("Remainder unit finished while no one was waiting.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (interval_reg <= 21'(INTERVAL_MAX)) && (interval_reg >= 21'(INTERVAL_MIN)))
        else $error("Tick interval left its saturation range.");

endmodule
